// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks an implication on every rising edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// same check, also active while reset is asserted
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/core/ort_pkg.sv -----
`timescale 1ns / 1ps

package ort_pkg;

  localparam int CUR_W    = 16;
  localparam int DT_W     = 16;
  localparam int BASE_W   = 10;
  localparam int RATING_W = 24;
  localparam int TC_W     = 16;
  localparam int LEVEL_W  = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // datapath widths
  localparam int SUM_W   = CUR_W + 1;              // prev + cur
  localparam int FLOW_W  = SUM_W + BASE_W;         // twice the flow, Q.12
  localparam int TWICE_RATING_W = RATING_W + 9;
  localparam int LDIFF_W = RATING_W + 1;           // signed rating difference
  localparam int LIM_W   = LDIFF_W + TC_W;         // signed limit
  localparam int INC_W   = FLOW_W + DT_W - 9;      // increment after >> 9
  localparam int MUL_A_W = FLOW_W + 1;
  localparam int MUL_B_W = DT_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_MVA     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATING_LONG  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATING_SHORT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CONST   = 8'd3;

  localparam logic [BASE_W-1:0]   BASE_MVA_RST     = 10'd100;
  localparam logic [RATING_W-1:0] RATING_LONG_RST  = 24'd16000000;
  localparam logic [RATING_W-1:0] RATING_SHORT_RST = 24'd16000000;
  localparam logic [TC_W-1:0]     TIME_CONST_RST   = 16'd1280;

  typedef struct packed {
    logic load;      // request accepted, capture operands
    logic mul_flow;  // multiply current sum by base
    logic mul_lim;   // compute excess sign and difference, multiply limit
    logic mul_inc;   // multiply excess by tick length
    logic update;    // integrate, compare, load result
  } cmd_t;

endpackage

// ----- rtl/core/ort_ctrl.sv -----
`timescale 1ns / 1ps

module ort_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ort_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FLOW = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_INC  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load     = in_valid_i && (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_FLOW;
      end
      S_FLOW: begin
        cmd_o.mul_flow = 1'b1;
        state_d        = S_SUB;
      end
      S_SUB: begin
        cmd_o.mul_lim = 1'b1;
        state_d       = S_INC;
      end
      S_INC: begin
        cmd_o.mul_inc = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        // hold until the previous result has been taken
        if (out_free) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/ort_datapath.sv -----
`timescale 1ns / 1ps

module ort_datapath #(
  parameter int ACCUM_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ort_pkg::cmd_t                    cmd_i,
  input  logic                             cfg_we_i,
  input  logic [ort_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ort_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [ort_pkg::CUR_W-1:0]        current_mag_i,
  input  logic [ort_pkg::DT_W-1:0]         tick_length_i,
  output logic                             trip_o,
  output logic                             closed_o,
  output logic [ort_pkg::LEVEL_W-1:0]      overload_level_o
);

  localparam int SAT_W = ((ACCUM_BITS > ort_pkg::INC_W) ? ACCUM_BITS : ort_pkg::INC_W) + 1;
  localparam int CMP_W = (ACCUM_BITS > ort_pkg::LIM_W) ? ACCUM_BITS : ort_pkg::LIM_W;
  localparam logic [ACCUM_BITS-1:0] ACC_FULL = {ACCUM_BITS{1'b1}};

  logic [ort_pkg::BASE_W-1:0]   base_q;
  logic [ort_pkg::RATING_W-1:0] rlt_q;
  logic [ort_pkg::RATING_W-1:0] rst_q;
  logic [ort_pkg::TC_W-1:0]     tc_q;

  logic [ort_pkg::CUR_W-1:0]    prev_q;
  logic [ort_pkg::SUM_W-1:0]    sum_q;
  logic [ort_pkg::DT_W-1:0]     dt_q;
  logic signed [ort_pkg::MUL_P_W-1:0] mul_q;
  logic [ort_pkg::FLOW_W-1:0]   diff_q;
  logic                         neg_q;
  logic signed [ort_pkg::LIM_W-1:0] lim_q;
  logic [ACCUM_BITS-1:0]        acc_q, acc_d;
  logic                         closed_q;
  logic                         trip_q;

  logic signed [ort_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ort_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ort_pkg::MUL_P_W-1:0] mul_p;
  logic signed [ort_pkg::LDIFF_W-1:0] rating_diff;
  logic [ort_pkg::FLOW_W-1:0]         flow;
  logic [ort_pkg::TWICE_RATING_W-1:0] twice_rating;
  logic [ort_pkg::INC_W-1:0]          inc;
  logic [SAT_W-1:0]                   sum_wide;
  logic [ACCUM_BITS-1:0]              acc_int;
  logic                               over;

  assign rating_diff  = $signed({1'b0, rst_q}) - $signed({1'b0, rlt_q});
  assign flow         = mul_q[ort_pkg::FLOW_W-1:0];
  assign twice_rating = {rlt_q, 9'b0};
  assign inc          = mul_q[ort_pkg::INC_W+8:9];

  // one shared multiplier for flow, limit and increment
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_flow) begin
      mul_a = $signed(ort_pkg::MUL_A_W'(sum_q));
      mul_b = $signed(ort_pkg::MUL_B_W'(base_q));
    end else if (cmd_i.mul_lim) begin
      mul_a = {{(ort_pkg::MUL_A_W-ort_pkg::LDIFF_W){rating_diff[ort_pkg::LDIFF_W-1]}},
               rating_diff};
      mul_b = $signed({1'b0, tc_q});
    end else if (cmd_i.mul_inc) begin
      mul_a = $signed({1'b0, diff_q});
      mul_b = $signed({1'b0, dt_q});
    end
  end

  assign mul_p = mul_a * mul_b;

  // saturating integration, then trip compare
  always_comb begin
    sum_wide = SAT_W'(acc_q) + SAT_W'(inc);
    if (neg_q) acc_int = '0;
    else if (sum_wide > SAT_W'(ACC_FULL)) acc_int = ACC_FULL;
    else acc_int = sum_wide[ACCUM_BITS-1:0];
    if (lim_q[ort_pkg::LIM_W-1]) over = 1'b1;
    else over = CMP_W'(acc_int) > CMP_W'(lim_q[ort_pkg::LIM_W-2:0]);
    acc_d = over ? '0 : acc_int;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= ort_pkg::BASE_MVA_RST;
      rlt_q    <= ort_pkg::RATING_LONG_RST;
      rst_q    <= ort_pkg::RATING_SHORT_RST;
      tc_q     <= ort_pkg::TIME_CONST_RST;
      prev_q   <= '0;
      acc_q    <= '0;
      closed_q <= 1'b1;
      trip_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ort_pkg::REG_BASE_MVA:     base_q <= cfg_data_i[ort_pkg::BASE_W-1:0];
          ort_pkg::REG_RATING_LONG:  rlt_q  <= cfg_data_i[ort_pkg::RATING_W-1:0];
          ort_pkg::REG_RATING_SHORT: rst_q  <= cfg_data_i[ort_pkg::RATING_W-1:0];
          ort_pkg::REG_TIME_CONST:   tc_q   <= cfg_data_i[ort_pkg::TC_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) prev_q <= current_mag_i;
      if (cmd_i.update) begin
        acc_q    <= acc_d;
        closed_q <= closed_q & ~over;
        trip_q   <= over;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q <= ort_pkg::SUM_W'(prev_q) + ort_pkg::SUM_W'(current_mag_i);
      dt_q  <= tick_length_i;
    end
    if (cmd_i.mul_flow || cmd_i.mul_lim || cmd_i.mul_inc) mul_q <= mul_p;
    if (cmd_i.mul_lim) begin
      neg_q  <= ort_pkg::TWICE_RATING_W'(flow) < twice_rating;
      diff_q <= flow - twice_rating[ort_pkg::FLOW_W-1:0];
    end
    if (cmd_i.mul_inc) lim_q <= mul_q[ort_pkg::LIM_W-1:0];
  end

  assign trip_o           = trip_q;
  assign closed_o         = closed_q;
  assign overload_level_o = ort_pkg::LEVEL_W'(acc_q);

endmodule

// ----- rtl/core/overload_relay_trip.sv -----
// Thermal overload relay integrator for one line. Each request carries a
// per-unit current (Q4.12) and a tick length (Q8.8 s); the block averages it
// with the previous current, scales by base MVA, subtracts the long-term
// rating and integrates the excess times dt into a saturating accumulator
// (cleared on negative excess). When the accumulator exceeds
// (short rating - long rating) * time constant the breaker latch opens until
// reset, trip is raised and the accumulator clears. One request is in work at
// a time: operands are captured at acceptance, then three products go through
// the single shared multiplier one per cycle, then the integrate-and-compare
// step loads the result; a new request is accepted only after that step. The
// result sits in an output register, so the next request is accepted while
// it waits; the final step stalls only if the previous result is still not
// taken. Configuration writes are always ready and take effect at once.
`timescale 1ns / 1ps

module overload_relay_trip #(
  parameter int ACCUM_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ort_pkg::CUR_W-1:0]       current_mag_i,
  input  logic [ort_pkg::DT_W-1:0]        tick_length_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            trip_o,
  output logic                            closed_o,
  output logic [ort_pkg::LEVEL_W-1:0]     overload_level_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ort_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ort_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ort_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  ort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ort_datapath #(
    .ACCUM_BITS (ACCUM_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .current_mag_i    (current_mag_i),
    .tick_length_i    (tick_length_i),
    .trip_o           (trip_o),
    .closed_o         (closed_o),
    .overload_level_o (overload_level_o)
  );

endmodule

// ----- rtl/core/ort_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ort_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            trip_o,
  input logic                            closed_o,
  input logic [ort_pkg::LEVEL_W-1:0]     overload_level_o
);

  // a result stays offered until taken
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // one request in work at a time
  `ASSERT_CLK(a_in_single, in_valid_i && in_ready_o |=> !in_ready_o)

  // an open breaker never closes again
  `ASSERT_CLK(a_latch_open, !closed_o |=> !closed_o)

  // a tripping tick shows the breaker open and the level cleared
  `ASSERT_CLK(a_trip_state, out_valid_o && trip_o |-> !closed_o && overload_level_o == '0)

endmodule

bind overload_relay_trip ort_checker u_checker (.*);
